[hw/rtl/caf_pkg.sv]
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants of the CAN acceptance filter designer.
// ----------------------------------------------------------------------------
`default_nettype none

package caf_pkg;

  // Identifier widths and limits
  localparam int ID_W          = 29;
  localparam int STD_BITS      = 11;
  localparam int EXT_BITS      = 29;
  localparam logic [ID_W-1:0] STD_MAX = 29'h7FF;
  localparam logic [ID_W-1:0] EXT_MAX = 29'h1FFF_FFFF;
  localparam logic [ID_W-1:0] ID_ONES = 29'h1FFF_FFFF;

  // Distinct-ID store
  localparam int MAX_IDS       = 64;
  localparam int CNT_W         = $clog2(MAX_IDS + 1);
  localparam int IDX_W         = $clog2(MAX_IDS);

  // Mask fit rule
  localparam int SLACK         = 8;
  localparam int MIN_MASK_BITS = 4;
  localparam int SLACK_W       = $clog2(SLACK * MAX_IDS + 1);
  localparam int K_MAX         = $clog2(SLACK * MAX_IDS + 1) - 1;
  localparam int KW            = $clog2(K_MAX + 1);
  localparam int TOT_W         = $clog2(EXT_BITS + 1);

  // Result field widths
  localparam int FCOUNT_W      = 7;

  // Queue between front and back
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_MASK     = 3'd1,
    MODE_LIST     = 3'd2,
    MODE_RANGE    = 3'd3,
    MODE_CAPACITY = 3'd4
  } filter_mode_t;

  typedef struct packed {
    logic            has_id;
    logic [ID_W-1:0] can_id;
    logic            last;
  } in_item_t;

  typedef struct packed {
    filter_mode_t        filter_mode;
    logic [FCOUNT_W-1:0] filter_count;
    logic [ID_W-1:0]     filter_id;
    logic [ID_W-1:0]     mask_or_max;
  } out_item_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic            has_id;
    logic            bad;
    logic            ext;
    logic            last;
    logic [ID_W-1:0] can_id;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_APPLY,
    B_ANSWER
  } back_state_t;

  // Control strobes of the back engine
  typedef struct packed {
    logic pop;
    logic rd;
    logic apply;
    logic load;
  } back_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/caf_front.sv]
// ----------------------------------------------------------------------------
// caf_front
// Accepts input words, range-checks the ID against the width selected now,
// drops words that carry neither an ID nor a close, and pushes the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_front import caf_pkg::*; (
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          in_stall,
  input  wire logic     extended_ids,
  input  wire logic     q_full,
  output logic          q_push,
  output entry_t        q_entry
);

  logic [ID_W-1:0] top;

  // Classify the word
  always_comb begin
    top              = extended_ids ? EXT_MAX : STD_MAX;
    q_entry.has_id   = in_data.has_id;
    q_entry.bad      = in_data.has_id && (in_data.can_id > top);
    q_entry.ext      = extended_ids;
    q_entry.last     = in_data.last;
    q_entry.can_id   = in_data.can_id;
  end

  // Hold off the source while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_data.has_id || in_data.last);

endmodule

`default_nettype wire

[hw/rtl/caf_queue.sv]
// ----------------------------------------------------------------------------
// caf_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_queue import caf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        q_valid,
  output entry_t      q_entry
);

  entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QFILL_W-1:0]   fill;

  assign full    = (fill == QFILL_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_entry = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/caf_back.sv]
// ----------------------------------------------------------------------------
// caf_back
// Dedups each ID against the stored set by a serial scan of the ID memory,
// keeps min, max, AND and OR, and builds the answer when a set closes.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_back import caf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire entry_t q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  back_state_t       state;
  back_state_t       state_next;
  back_ctl_t         ctl;

  entry_t            cur;
  logic              found;
  logic [CNT_W-1:0]  idx;
  logic [ID_W-1:0]   rd_data;
  logic [ID_W-1:0]   seen_ids [MAX_IDS];

  logic [CNT_W-1:0]  distinct_count;
  logic [ID_W-1:0]   common_ones;
  logic [ID_W-1:0]   any_ones;
  logic [ID_W-1:0]   smallest_id;
  logic [ID_W-1:0]   largest_id;
  logic              range_fault;
  logic [ID_W-1:0]   fault_id;
  logic              capacity_fault;

  logic              at_capacity;
  logic              store;
  logic              out_room;
  logic              scan_done;
  out_item_t         answer;

  assign at_capacity = (distinct_count == CNT_W'(MAX_IDS));
  assign store       = ctl.apply && cur.has_id && !cur.bad && !found && !at_capacity;
  assign out_room    = !out_valid || !out_stall;
  assign scan_done   = (idx + CNT_W'(1) == distinct_count);
  assign q_pop       = ctl.pop;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_entry.has_id && !q_entry.bad && (distinct_count != '0)) begin
            state_next = B_READ;
          end else begin
            state_next = B_APPLY;
          end
        end
      end
      B_READ: begin
        state_next = B_CMP;
      end
      B_CMP: begin
        if ((rd_data == cur.can_id) || scan_done) begin
          state_next = B_APPLY;
        end else begin
          state_next = B_READ;
        end
      end
      B_APPLY: begin
        state_next = cur.last ? B_ANSWER : B_IDLE;
      end
      B_ANSWER: begin
        if (out_room) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Control strobes
  always_comb begin
    ctl = '0;
    case (state)
      B_IDLE:   ctl.pop   = q_valid;
      B_READ:   ctl.rd    = 1'b1;
      B_CMP:    ctl       = '0;
      B_APPLY:  ctl.apply = 1'b1;
      B_ANSWER: ctl.load  = out_room;
      default:  ctl       = '0;
    endcase
  end

  // Build the answer from the set statistics
  logic [ID_W-1:0]    top;
  logic [TOT_W-1:0]   total;
  logic [ID_W-1:0]    diff;
  logic               diff_high;
  logic [KW-1:0]      k;
  logic [SLACK_W-1:0] span;
  logic [SLACK_W-1:0] budget;
  logic               fits;
  logic [ID_W-1:0]    low_bits;
  logic [ID_W-1:0]    mask;

  always_comb begin
    top       = cur.ext ? EXT_MAX : STD_MAX;
    total     = cur.ext ? TOT_W'(EXT_BITS) : TOT_W'(STD_BITS);
    diff      = (common_ones ^ any_ones) & top;
    diff_high = |diff[ID_W-1:K_MAX];
    // Free low bits follow the highest differing bit, at least one
    k = KW'(1);
    for (int j = 1; j < K_MAX; j++) begin
      if (diff[j]) begin
        k = KW'(j + 1);
      end
    end
    span     = SLACK_W'(1) << k;
    budget   = SLACK_W'(distinct_count) * SLACK_W'(SLACK);
    fits     = !diff_high && (TOT_W'(k) <= total - TOT_W'(MIN_MASK_BITS)) &&
               (span <= budget);
    low_bits = (ID_W'(1) << k) - ID_W'(1);
    mask     = top & ~low_bits;

    answer = '0;
    if (range_fault) begin
      answer.filter_mode = MODE_RANGE;
      answer.filter_id   = fault_id;
    end else if (capacity_fault) begin
      answer.filter_mode = MODE_CAPACITY;
    end else if (distinct_count == '0) begin
      answer.filter_mode = MODE_NONE;
    end else if (distinct_count == CNT_W'(1)) begin
      answer.filter_mode  = MODE_MASK;
      answer.filter_count = FCOUNT_W'(1);
      answer.filter_id    = smallest_id;
      answer.mask_or_max  = top;
    end else if (fits) begin
      answer.filter_mode  = MODE_MASK;
      answer.filter_count = FCOUNT_W'(1);
      answer.filter_id    = common_ones & mask;
      answer.mask_or_max  = mask;
    end else begin
      answer.filter_mode  = MODE_LIST;
      answer.filter_count = FCOUNT_W'(distinct_count);
      answer.filter_id    = smallest_id;
      answer.mask_or_max  = largest_id;
    end
  end

  // Control state and set statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      found          <= 1'b0;
      idx            <= '0;
      out_valid      <= 1'b0;
      distinct_count <= '0;
      common_ones    <= ID_ONES;
      any_ones       <= '0;
      smallest_id    <= ID_ONES;
      largest_id     <= '0;
      range_fault    <= 1'b0;
      fault_id       <= '0;
      capacity_fault <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.pop) begin
        found <= 1'b0;
        idx   <= '0;
      end
      if (state == B_CMP) begin
        if (rd_data == cur.can_id) begin
          found <= 1'b1;
        end
        idx <= idx + CNT_W'(1);
      end
      if (ctl.apply && cur.has_id) begin
        if (cur.bad) begin
          if (!range_fault) begin
            range_fault <= 1'b1;
            fault_id    <= cur.can_id;
          end
        end else if (!found && at_capacity) begin
          capacity_fault <= 1'b1;
        end
      end
      if (store) begin
        distinct_count <= distinct_count + CNT_W'(1);
        common_ones    <= common_ones & cur.can_id;
        any_ones       <= any_ones | cur.can_id;
        if (cur.can_id < smallest_id) begin
          smallest_id <= cur.can_id;
        end
        if (cur.can_id > largest_id) begin
          largest_id <= cur.can_id;
        end
      end
      // Drop the set once its answer is loaded
      if (ctl.load) begin
        distinct_count <= '0;
        common_ones    <= ID_ONES;
        any_ones       <= '0;
        smallest_id    <= ID_ONES;
        largest_id     <= '0;
        range_fault    <= 1'b0;
        fault_id       <= '0;
        capacity_fault <= 1'b0;
      end
      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers and ID memory
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur <= q_entry;
    end
    if (ctl.rd) begin
      rd_data <= seen_ids[idx[IDX_W-1:0]];
    end
    if (store) begin
      seen_ids[distinct_count[IDX_W-1:0]] <= cur.can_id;
    end
    if (ctl.load) begin
      out_data <= answer;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/can_acceptance_filter_designer.sv]
// ----------------------------------------------------------------------------
// can_acceptance_filter_designer
// Collects a set of CAN IDs and answers with a mask filter, a filter list,
// or an error when the set closes.
// ----------------------------------------------------------------------------
//   channel   signals                       direction   word
//   in        in_valid/in_stall/in_data     input       in_item_t
//   out       out_valid/out_stall/out_data  output      out_item_t
//   cfg       cfg_valid/cfg_ready/cfg_data  input       extended_ids bit
//
// The back engine compares an ID with the N distinct IDs stored so far: the
// ID memory is scanned through its registered read port, a read state and a
// compare state per entry, to a match. A closing word then loads the answer.
// The front takes words while the four-entry queue has room.
// Reset clears control state and set statistics; the ID memory is not cleared.
// out_stall holds the answer register; the back then waits, and in_stall
// rises once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module can_acceptance_filter_designer import caf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  logic   extended_ids;
  logic   q_full;
  logic   q_push;
  entry_t push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t q_entry;

  assign cfg_ready = 1'b1;

  // Width select register
  always_ff @(posedge clk) begin
    if (rst) begin
      extended_ids <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      extended_ids <= cfg_data;
    end
  end

  caf_front u_front (
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .extended_ids (extended_ids),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  caf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  caf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/caf_checker.sv]
// ----------------------------------------------------------------------------
// caf_checker
// Port-level checks on the answers of the filter designer.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_checker import caf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // Hold a stalled answer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled answer changed");

  // One filter exactly in mask mode
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.filter_mode == MODE_MASK) ==
                   (out_data.filter_count == FCOUNT_W'(1))))
    else $error("mask mode and filter count disagree");

  // Capacity error and empty set carry no filter
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.filter_mode == MODE_NONE ||
                  out_data.filter_mode == MODE_CAPACITY) |->
    out_data.filter_id == '0 && out_data.mask_or_max == '0 &&
    out_data.filter_count == '0)
    else $error("empty or capacity answer carries data");

  // List bounds are ordered
  a_list: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.filter_mode == MODE_LIST |->
    out_data.filter_id <= out_data.mask_or_max)
    else $error("list minimum above maximum");

  // No answer right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("answer valid after reset");

endmodule

bind can_acceptance_filter_designer caf_checker u_caf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Streams sets of CAN IDs through the filter designer, a few chosen by hand
// and then many at random, under both ID widths. A scoreboard class follows
// each accepted word, works out the answer that each closing word should
// bring and checks the answers that come back, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import caf_pkg::*;

  localparam int IDLE_PCT  = 31;
  localparam int ITEMS     = 1600;
  // worst queue backlog behind the slowest ID scan, with margin
  localparam int DRAIN     = (QUEUE_DEPTH + 2) * (2 * MAX_IDS + 4);
  localparam int WATCHDOG  = 20000;
  localparam int CFG_EVERY = 40;

  // Track the set being collected and the answers still owed
  class filter_tracker;
    bit              wide;
    logic [ID_W-1:0] kept_ids[$];
    logic [ID_W-1:0] and_bits, or_bits, low_id, high_id, bad_id;
    bit              out_of_range, overflow;
    out_item_t       due_answers[$];
    int              errors;

    function new();
      wide   = 1'b0;
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      kept_ids.delete();
      and_bits     = ID_ONES;
      or_bits      = '0;
      low_id       = ID_ONES;
      high_id      = '0;
      bad_id       = '0;
      out_of_range = 1'b0;
      overflow     = 1'b0;
    endfunction

    function logic [ID_W-1:0] id_limit();
      return wide ? EXT_MAX : STD_MAX;
    endfunction

    // Range check, drop duplicates, flag overflow when full, else store and fold into the statistics
    function void absorb_id(logic [ID_W-1:0] id);
      if (id > id_limit()) begin
        if (!out_of_range) begin
          out_of_range = 1'b1;
          bad_id       = id;
        end
        return;
      end
      foreach (kept_ids[i]) begin
        if (kept_ids[i] == id) return;
      end
      if (kept_ids.size() >= MAX_IDS) begin
        overflow = 1'b1;
        return;
      end
      kept_ids = {kept_ids, id};
      and_bits &= id;
      or_bits  |= id;
      if (id < low_id) low_id = id;
      if (id > high_id) high_id = id;
    endfunction

    // Pick the answer for the closing word at the width now selected
    function out_item_t plan_answer();
      out_item_t       a;
      logic [ID_W-1:0] top, diff;
      int              total, prefix, m;
      top   = id_limit();
      total = wide ? EXT_BITS : STD_BITS;
      a     = '0;
      a.filter_mode = MODE_NONE;
      if (out_of_range) begin
        a.filter_mode = MODE_RANGE;
        a.filter_id   = bad_id;
      end else if (overflow) begin
        a.filter_mode = MODE_CAPACITY;
      end else if (kept_ids.size() == 1) begin
        a.filter_mode  = MODE_MASK;
        a.filter_count = FCOUNT_W'(1);
        a.filter_id    = kept_ids[0];
        a.mask_or_max  = top;
      end else if (kept_ids.size() > 1) begin
        // length of the leading prefix that all stored IDs share
        diff   = (and_bits ^ or_bits) & top;
        prefix = 0;
        while (prefix < total && !diff[total - 1 - prefix]) prefix++;
        m = (prefix < total - 1) ? prefix : total - 1;
        if (m >= MIN_MASK_BITS &&
            (64'd1 << (total - m)) <= 64'(kept_ids.size() * SLACK)) begin
          a.filter_mode  = MODE_MASK;
          a.filter_count = FCOUNT_W'(1);
          a.mask_or_max  = (ID_ONES << (total - m)) & top;
          a.filter_id    = and_bits & a.mask_or_max;
        end else begin
          a.filter_mode  = MODE_LIST;
          a.filter_count = FCOUNT_W'(kept_ids.size());
          a.filter_id    = low_id;
          a.mask_or_max  = high_id;
        end
      end
      return a;
    endfunction

    // Note one accepted input word
    function void take_word(in_item_t w);
      if (w.has_id) absorb_id(w.can_id);
      if (w.last) begin
        due_answers = {due_answers, plan_answer()};
        clear_set();
      end
    endfunction

    // Check one accepted answer word against the oldest one owed
    function void match_answer(out_item_t got);
      out_item_t want;
      if (due_answers.size() == 0) begin
        $error("answer word with none owed: filter_mode %0d filter_id %0h",
               got.filter_mode, got.filter_id);
        errors++;
        return;
      end
      want = due_answers.pop_front();
      if (got.filter_mode !== want.filter_mode) begin
        $error("filter_mode: expected %0d, got %0d", want.filter_mode, got.filter_mode);
        errors++;
      end
      if (got.filter_count !== want.filter_count) begin
        $error("filter_count: expected %0d, got %0d", want.filter_count, got.filter_count);
        errors++;
      end
      if (got.filter_id !== want.filter_id) begin
        $error("filter_id: expected %0h, got %0h", want.filter_id, got.filter_id);
        errors++;
      end
      if (got.mask_or_max !== want.mask_or_max) begin
        $error("mask_or_max: expected %0h, got %0h", want.mask_or_max, got.mask_or_max);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  bit        steady       = 1'b0;
  int        sent         = 0;
  int        quiet_cycles = 0;
  bit        moved;
  filter_tracker book = new();

  can_acceptance_filter_designer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample every channel, randomize the output stall, watch for a hang
  always @(posedge clk) begin
    moved = 1'b0;
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    if (!rst) begin
      if (in_valid && !in_stall) begin
        book.take_word(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        book.match_answer(out_data);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        book.wide = cfg_data;
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input bit has, input logic [ID_W-1:0] id, input bit fin);
    in_item_t w;
    w.has_id = has;
    w.can_id = id;
    w.last   = fin;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (has || fin) sent++;
  endtask

  // Hold the sender until every owed answer has come back
  task automatic wait_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.due_answers.size() != 0) @(posedge clk);
  endtask

  // Let the block finish any ID still in flight
  task automatic settle();
    wait_answers();
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_width(input bit ext);
    cfg_valid <= 1'b1;
    cfg_data  <= ext;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random set: IDs share a random prefix with k free low bits,
  // with duplicates, stray out-of-range IDs and empty words mixed in
  task automatic random_set();
    int              n, k, total, pick, r;
    logic [ID_W-1:0] top, low, base, id, prev;
    bit              trailer;
    top   = book.wide ? EXT_MAX : STD_MAX;
    total = book.wide ? EXT_BITS : STD_BITS;
    pick  = $urandom_range(99);
    if (pick < 2) begin
      n = $urandom_range(60, 70);
      k = $urandom_range(6, total);
    end else if (pick < 7) begin
      n = 0;
      k = total;
    end else begin
      n = $urandom_range(1, 12);
      k = (pick < 55) ? $urandom_range(1, 6) :
          (pick < 80) ? $urandom_range(7, total) : total;
    end
    low     = (k >= ID_W) ? ID_ONES : ((ID_W'(1) << k) - ID_W'(1));
    base    = ID_W'($urandom) & top;
    prev    = base;
    trailer = (n == 0) || ($urandom_range(99) < 20);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) id = prev;
      else if (r < 13 && !book.wide) id = ID_W'($urandom);
      else id = (base & ~low) | (ID_W'($urandom) & low & top);
      if ($urandom_range(99) < 8) send_word(1'b0, ID_W'($urandom), 1'b0);
      // switch width in the middle of a set now and then
      if (i == n / 2 && $urandom_range(99) < 2) begin
        settle();
        write_width(!book.wide);
      end
      send_word(1'b1, id, (i == n - 1) && !trailer);
      prev = id;
    end
    if (trailer) send_word(1'b0, ID_W'($urandom), 1'b1);
  endtask

  initial begin
    int sets;
    sets = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // standard IDs: empty set, ignored word, single IDs at both ends
    send_word(1'b0, '0, 1'b1);
    send_word(1'b0, ID_W'($urandom), 1'b0);
    send_word(1'b1, '0, 1'b1);
    send_word(1'b1, STD_MAX, 1'b1);
    // first out-of-range ID wins
    send_word(1'b1, ID_W'('h800), 1'b0);
    send_word(1'b1, EXT_MAX, 1'b0);
    send_word(1'b1, ID_W'(5), 1'b1);
    // duplicates collapse to one ID
    send_word(1'b1, ID_W'('h123), 1'b0);
    send_word(1'b1, ID_W'('h123), 1'b0);
    send_word(1'b1, ID_W'('h123), 1'b1);
    // mask fits, then a list with no common prefix
    send_word(1'b1, ID_W'('h120), 1'b0);
    send_word(1'b1, ID_W'('h127), 1'b0);
    send_word(1'b1, ID_W'('h125), 1'b1);
    send_word(1'b1, '0, 1'b0);
    send_word(1'b1, STD_MAX, 1'b1);

    // extended IDs: top single ID, longest mask, widest list
    settle();
    write_width(1'b1);
    send_word(1'b1, EXT_MAX, 1'b1);
    send_word(1'b1, ID_W'('h1FFF_FFFE), 1'b0);
    send_word(1'b1, EXT_MAX, 1'b1);
    send_word(1'b1, '0, 1'b0);
    send_word(1'b1, EXT_MAX, 1'b1);
    // width narrows in the middle of a set
    send_word(1'b1, ID_W'('h1000_0123), 1'b0);
    settle();
    write_width(1'b0);
    send_word(1'b1, ID_W'('h122), 1'b1);

    // random sets
    while (sent < ITEMS) begin
      steady = (sets >= 100 && sets < 130);
      random_set();
      sets++;
      if (sets % CFG_EVERY == 0) begin
        settle();
        write_width(!book.wide);
      end else if ($urandom_range(99) < 4) begin
        wait_answers();
      end
    end
    steady = 1'b0;

    wait_answers();
    repeat (DRAIN) @(posedge clk);
    if (book.errors == 0 && book.due_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
